/* design/wcp_pkg.sv */
`timescale 1ns / 1ps

package wcp_pkg;

    localparam int ByteW   = 8;
    localparam int CountW  = 24;
    localparam int IdW     = 32;
    localparam int FmtLen  = 16;
    localparam int HdrLen  = 5;

    localparam logic [IdW-1:0] ID_FMT  = 32'h666D_7420;  // "fmt "
    localparam logic [IdW-1:0] ID_DATA = 32'h6461_7461;  // "data"

    typedef enum logic [1:0] {
        PH_RIFF = 2'd0,
        PH_HDR  = 2'd1,
        PH_BODY = 2'd2,
        PH_END  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_FMT   = 2'd1,
        KIND_DATA  = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ERR_NONE       = 4'd0,
        ERR_HEADER     = 4'd1,
        ERR_BIG_BLOCK  = 4'd2,
        ERR_MULTI_FMT  = 4'd3,
        ERR_FMT_SMALL  = 4'd4,
        ERR_CHANNELS   = 4'd5,
        ERR_RATE       = 4'd6,
        ERR_BITS       = 4'd7,
        ERR_CODEC      = 4'd8,
        ERR_DATA_FIRST = 4'd9
    } t_err_code;

    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,
        CMD_ERROR = 2'd1,
        CMD_FMT   = 2'd2
    } t_cmd_kind;

    // One queue entry: a pass-through byte, an error report, or a fmt header.
    typedef struct packed {
        t_cmd_kind                     kind;
        t_err_code                     code;
        logic [HdrLen-1:0][ByteW-1:0]  data;
    } t_cmd;

    // Expected bytes of the 12-byte RIFF/WAVE preamble; size bytes are don't care.
    function automatic logic [ByteW-1:0] magic_byte(input logic [3:0] idx);
        logic [ByteW-1:0] v;
        begin
            case (idx)
                4'd0:    v = 8'h52;  // R
                4'd1:    v = 8'h49;  // I
                4'd2:    v = 8'h46;  // F
                4'd3:    v = 8'h46;  // F
                4'd8:    v = 8'h57;  // W
                4'd9:    v = 8'h41;  // A
                4'd10:   v = 8'h56;  // V
                4'd11:   v = 8'h45;  // E
                default: v = 8'h00;
            endcase
            return v;
        end
    endfunction

endpackage

/* design/wcp_front.sv */
`timescale 1ns / 1ps

module wcp_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [wcp_pkg::ByteW-1:0] i_in_byte,
    input  logic                      i_in_end,
    input  logic                      i_q_full,
    output logic                      o_push,
    output wcp_pkg::t_cmd             o_cmd
);
    import wcp_pkg::*;

    t_phase                 r_phase, n_phase;
    logic [CountW-1:0]      r_count, n_count;
    logic [CountW-1:0]      r_size, n_size;
    logic [IdW-1:0]         r_id, n_id;
    t_kind                  r_kind, n_kind;
    logic                   r_riff_ok, n_riff_ok;
    logic                   r_fmt_seen, n_fmt_seen;
    logic [ByteW-1:0]       r_fmt [FmtLen];

    logic                   accept;
    logic                   fmt_we;
    logic                   err;
    t_err_code              err_code;
    logic                   riff_match;
    logic                   body_last;
    logic [ByteW-1:0]       d15;
    logic [ByteW-1:0]       codec;
    t_kind                  hdr_kind;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    assign riff_match = (r_count[3:0] >= 4'd4 && r_count[3:0] <= 4'd7)
                        || (i_in_byte == magic_byte(r_count[3:0]));
    assign body_last  = ({1'b0, r_count} + {{CountW{1'b0}}, 1'b1}) == {1'b0, r_size};
    // Byte 15 may be arriving right now when the chunk is exactly 16 bytes.
    assign d15   = (r_count == CountW'(FmtLen - 1)) ? i_in_byte : r_fmt[15];
    assign codec = (r_fmt[0] == 8'd1) ? ((r_fmt[14] == 8'd8) ? 8'd0 : 8'd4) : r_fmt[0];
    assign fmt_we = accept && (r_phase == PH_BODY) && (r_kind == KIND_FMT)
                    && (r_count[CountW-1:4] == '0);

    always_comb begin
        if (r_id == ID_FMT) begin
            hdr_kind = KIND_FMT;
        end else if (r_id == ID_DATA) begin
            hdr_kind = KIND_DATA;
        end else begin
            hdr_kind = KIND_OTHER;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_size     = r_size;
        n_id       = r_id;
        n_kind     = r_kind;
        n_riff_ok  = r_riff_ok;
        n_fmt_seen = r_fmt_seen;
        err        = 1'b0;
        err_code   = ERR_NONE;
        o_push     = 1'b0;
        o_cmd.kind = CMD_BYTE;
        o_cmd.code = ERR_NONE;
        o_cmd.data = '0;

        if (accept && r_phase != PH_END) begin
            case (r_phase)
                PH_RIFF: begin
                    n_riff_ok = r_riff_ok && riff_match;
                    if (r_count[3:0] == 4'd11) begin
                        if (!n_riff_ok) begin
                            err      = 1'b1;
                            err_code = ERR_HEADER;
                        end else begin
                            n_phase = PH_HDR;
                            n_count = '0;
                        end
                    end else if (i_in_end) begin
                        err      = 1'b1;
                        err_code = ERR_HEADER;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
                PH_HDR: begin
                    case (r_count[2:0])
                        3'd0, 3'd1, 3'd2, 3'd3: n_id = {r_id[IdW-ByteW-1:0], i_in_byte};
                        3'd4:    n_size[7:0]   = i_in_byte;
                        3'd5:    n_size[15:8]  = i_in_byte;
                        3'd6:    n_size[23:16] = i_in_byte;
                        default: ;
                    endcase
                    if (r_count[2:0] == 3'd7) begin
                        if (i_in_byte != '0) begin
                            err      = 1'b1;
                            err_code = ERR_BIG_BLOCK;
                        end else begin
                            n_kind  = hdr_kind;
                            n_count = '0;
                            if (r_size != '0) begin
                                if (hdr_kind == KIND_DATA && !r_fmt_seen) begin
                                    err      = 1'b1;
                                    err_code = ERR_DATA_FIRST;
                                end else begin
                                    n_phase = PH_BODY;
                                end
                            end
                        end
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
                PH_BODY: begin
                    if (r_kind == KIND_DATA) begin
                        o_push        = 1'b1;
                        o_cmd.data[0] = i_in_byte;
                    end
                    if (body_last) begin
                        n_phase = PH_HDR;
                        n_count = '0;
                        if (r_kind == KIND_FMT) begin
                            // Validate in a fixed order; first failing check wins.
                            err = 1'b1;
                            if (r_fmt_seen) begin
                                err_code = ERR_MULTI_FMT;
                            end else if (r_size < CountW'(FmtLen)) begin
                                err_code = ERR_FMT_SMALL;
                            end else if (r_fmt[2] > 8'd2 || r_fmt[3] != '0) begin
                                err_code = ERR_CHANNELS;
                            end else if (r_fmt[6] != '0 || r_fmt[7] != '0) begin
                                err_code = ERR_RATE;
                            end else if ((r_fmt[14] != 8'd8 && r_fmt[14] != 8'd16)
                                         || d15 != '0) begin
                                err_code = ERR_BITS;
                            end else if ((r_fmt[0] != 8'd1 && r_fmt[0] != 8'd6
                                          && r_fmt[0] != 8'd7) || r_fmt[1] != '0) begin
                                err_code = ERR_CODEC;
                            end else begin
                                err           = 1'b0;
                                n_fmt_seen    = 1'b1;
                                o_push        = 1'b1;
                                o_cmd.kind    = CMD_FMT;
                                o_cmd.data[0] = 8'd4;
                                o_cmd.data[1] = (r_fmt[2] == 8'd2) ? 8'd5 : 8'd1;
                                o_cmd.data[2] = codec;
                                o_cmd.data[3] = r_fmt[4];
                                o_cmd.data[4] = r_fmt[5];
                            end
                        end
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
                default: ;
            endcase

            if (err) begin
                o_push     = 1'b1;
                o_cmd.kind = CMD_ERROR;
                o_cmd.code = err_code;
                o_cmd.data = '0;
                n_phase    = PH_END;
            end else if (i_in_end) begin
                n_phase = PH_END;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_RIFF;
            r_count    <= '0;
            r_size     <= '0;
            r_id       <= '0;
            r_kind     <= KIND_OTHER;
            r_riff_ok  <= 1'b1;
            r_fmt_seen <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_size     <= n_size;
            r_id       <= n_id;
            r_kind     <= n_kind;
            r_riff_ok  <= n_riff_ok;
            r_fmt_seen <= n_fmt_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fmt_we) begin
            r_fmt[r_count[3:0]] <= i_in_byte;
        end
    end

    a_end_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_END) |=> (r_phase == PH_END))
        else $error("front left the end state without reset");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_full)
        else $error("front pushed into a full queue");

    a_body_size_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_size != '0 && r_count < r_size))
        else $error("body count outside chunk size");

endmodule

/* design/wcp_queue.sv */
`timescale 1ns / 1ps

module wcp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wcp_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_avail,
    output wcp_pkg::t_cmd o_cmd
);
    import wcp_pkg::*;

    t_cmd        r_slot [2];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_avail = (r_count != 2'd0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_count  = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("queue count out of range");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_avail)
        else $error("pop from empty queue");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule

/* design/wcp_back.sv */
`timescale 1ns / 1ps

module wcp_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_avail,
    input  wcp_pkg::t_cmd             i_cmd,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [wcp_pkg::ByteW-1:0] o_out_byte,
    output logic                      o_out_error,
    output logic [3:0]                o_error_code,
    output logic                      o_out_last
);
    import wcp_pkg::*;

    logic        r_valid, n_valid;
    t_cmd        r_cmd, n_cmd;
    logic [2:0]  r_idx, n_idx;
    logic        cur_last;
    logic        advance;

    assign cur_last = (r_cmd.kind != CMD_FMT) || (r_idx == 3'(HdrLen - 1));
    assign advance  = !r_valid || (i_out_ready && cur_last);
    assign o_pop    = advance && i_avail;

    always_comb begin
        n_valid = r_valid;
        n_cmd   = r_cmd;
        n_idx   = r_idx;
        if (advance) begin
            n_valid = i_avail;
            n_idx   = '0;
            if (i_avail) begin
                n_cmd = i_cmd;
            end
        end else if (i_out_ready) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    assign o_out_valid  = r_valid;
    assign o_out_byte   = r_cmd.data[r_idx];
    assign o_out_error  = (r_cmd.kind == CMD_ERROR);
    assign o_error_code = r_cmd.code;
    assign o_out_last   = cur_last;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_idx <= 3'(HdrLen - 1)))
        else $error("header index out of range");

    a_single_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_cmd.kind != CMD_FMT) |-> (r_idx == '0))
        else $error("single-result command advanced its index");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_out_ready) |=> (r_valid && $stable(r_idx)))
        else $error("stalled result moved");

endmodule

/* design/wav_chunk_parser.sv */
`timescale 1ns / 1ps

// RIFF/WAVE chunk parser, one stream byte per request. The front end checks the
// 12-byte RIFF....WAVE preamble, walks 8-byte chunk headers (little-endian
// 24-bit size; a nonzero top size byte is error 2), skips empty and unknown
// chunks, captures a "fmt " chunk and validates it at its last byte, and turns
// every "data" byte into one result. A valid fmt chunk yields a 5-byte header
// (4, channel code, codec, rate low, rate high) with out_last on the fifth.
// The first error yields one error result and the block then stays silent until
// reset, as it does after the byte marked in_end. Throughput is one input
// request per cycle: the front end classifies each byte combinationally and
// posts at most one command into a two-entry queue; the back end drains one
// result per cycle from its output register while the output side is ready, so
// a fmt header holds it for all five of its bytes. The next chunk header is
// eight bytes that post nothing, which lets those five bytes go out, so the
// input stalls only while the output side holds ready low long enough to fill
// the queue. An accepted byte reaches the output through a queue slot and then
// the back end's output register. No clearing pass is needed after reset.
module wav_chunk_parser (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [wcp_pkg::ByteW-1:0] i_in_byte,
    input  logic                      i_in_end,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [wcp_pkg::ByteW-1:0] o_out_byte,
    output logic                      o_out_error,
    output logic [3:0]                o_error_code,
    output logic                      o_out_last
);
    import wcp_pkg::*;

    // Commands from the classifier into the queue.
    logic  push;
    logic  q_full;
    t_cmd  push_cmd;

    // Commands from the queue into the result emitter.
    logic  pop;
    logic  q_avail;
    t_cmd  head_cmd;

    // Front end: parse and classify each accepted byte.
    wcp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .i_in_end   (i_in_end),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    // Decouple: hold up to two commands so either side can stall alone.
    wcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_avail (q_avail),
        .o_cmd   (head_cmd)
    );

    // Back end: expand each command into its result requests.
    wcp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_avail      (q_avail),
        .i_cmd        (head_cmd),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_out_error  (o_out_error),
        .o_error_code (o_error_code),
        .o_out_last   (o_out_last)
    );

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

// Stream-level check of the RIFF/WAVE chunk parser. Because the block goes
// silent for good after its first error or after the byte flagged as the end
// of the stream, each run is a single WAV stream. The seed picks how that
// stream opens and how it closes:
// - most runs carry a good header, empty and unknown chunks, one valid fmt
//   chunk and then a long run of data chunks, followed by one closing case;
// - the rest stop early on a bad preamble, a short preamble, data before fmt,
//   or a fmt chunk with one fault.
// Every accepted request goes through a local parser model, and each result
// the block returns is compared, in order, with what that model produced.
module tb;
    import wcp_pkg::*;

    localparam int CYCLE_LIMIT   = 100000;
    localparam int QUIET_FROM    = 200;   // window with no random idling on either side
    localparam int QUIET_TO      = 700;
    localparam int IDLE_PCT      = 13;
    localparam int SETTLE_CYCLES = 20;
    localparam int BODY_ITEMS    = 250;
    localparam int STREAM_ITEMS  = 270;

    localparam logic [IdW-1:0] TAG_RIFF = "RIFF";
    localparam logic [IdW-1:0] TAG_WAVE = "WAVE";
    localparam logic [IdW-1:0] TAG_LIST = "LIST";

    // fmt chunk field values
    localparam logic [ByteW-1:0] CODEC_PCM  = 8'd1;
    localparam logic [ByteW-1:0] CODEC_ALAW = 8'd6;
    localparam logic [ByteW-1:0] CODEC_ULAW = 8'd7;
    localparam logic [ByteW-1:0] BITS_8     = 8'd8;
    localparam logic [ByteW-1:0] BITS_16    = 8'd16;
    localparam logic [ByteW-1:0] MAX_CHANS  = 8'd2;

    // Output header codes
    localparam logic [ByteW-1:0] HDR_TAG    = 8'd4;
    localparam logic [ByteW-1:0] HDR_STEREO = 8'd5;
    localparam logic [ByteW-1:0] HDR_MONO   = 8'd1;
    localparam logic [ByteW-1:0] PCM_8_CODE = 8'd0;
    localparam logic [ByteW-1:0] PCM_16_CODE = 8'd4;

    typedef struct packed {
        logic [ByteW-1:0] b;
        logic             fin;
        logic             hold;   // hold this request until every result is back
    } t_stream_req;

    typedef struct packed {
        logic [ByteW-1:0] b;
        logic             err;
        t_err_code        code;
        logic             last;
    } t_parsed;

    typedef enum int {
        OPEN_CLEAN, OPEN_BAD_MAGIC, OPEN_SHORT, OPEN_DATA_FIRST, OPEN_BAD_FMT
    } t_opening;

    typedef enum int {
        CLOSE_CLEAN, CLOSE_CUT_BODY, CLOSE_CUT_HDR, CLOSE_BIG_BLOCK,
        CLOSE_SECOND_FMT, CLOSE_CUT_FMT
    } t_closing;

    typedef enum int {
        FMT_OK, FMT_SMALL, FMT_CHAN, FMT_RATE, FMT_BITS, FMT_CODEC
    } t_fmt_fault;

    logic             i_clk;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_ready;
    logic [ByteW-1:0] i_in_byte   = '0;
    logic             i_in_end    = 1'b0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [ByteW-1:0] o_out_byte;
    logic             o_out_error;
    logic [3:0]       o_error_code;
    logic             o_out_last;

    wav_chunk_parser i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .i_in_end     (i_in_end),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_out_error  (o_out_error),
        .o_error_code (o_error_code),
        .o_out_last   (o_out_last)
    );

    // Parser model state
    t_phase           ph;
    t_kind            kind;
    logic [CountW-1:0] pos;
    logic [CountW-1:0] csize;
    logic [IdW-1:0]   cid;
    logic             riff_good;
    logic             fmt_done;
    logic             halted;
    logic [ByteW-1:0] fmt_mem [FmtLen];

    t_stream_req stream_q [$];
    t_parsed     parsed_q [$];
    t_stream_req next_req;
    t_parsed     head_res;
    logic        hold_pending = 1'b0;
    int          cycle_cnt    = 0;
    int          fail_cnt     = 0;
    logic        quiet;

    assign quiet = (cycle_cnt >= QUIET_FROM) && (cycle_cnt < QUIET_TO);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Release reset from the cycle counter; abort a run that hangs.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == 1) begin
            i_rst_n <= 1'b1;
        end
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------
    task automatic emit(input logic [ByteW-1:0] b, input logic err, input t_err_code code,
                        input logic last);
        parsed_q.push_back('{b, err, code, last});
    endtask

    // Report the error once and go silent until reset.
    task automatic raise_err(input t_err_code code);
        emit('0, 1'b1, code, 1'b1);
        halted = 1'b1;
    endtask

    task automatic parse_wav_byte(input logic [ByteW-1:0] b, input logic fin);
        logic [CountW-1:0] i;
        logic [ByteW-1:0]  want;
        logic [ByteW-1:0]  codec_out;
        if (halted || ph == PH_END) return;
        i = pos;
        case (ph)
            PH_RIFF: begin
                // Bytes 4..7 carry the file size and are not checked.
                if (i < 4 || i >= 8) begin
                    want = (i < 4) ? TAG_RIFF[8*(3-i) +: 8] : TAG_WAVE[8*(11-i) +: 8];
                    if (b != want) riff_good = 1'b0;
                end
                if (i >= 11) begin
                    if (!riff_good) begin
                        raise_err(ERR_HEADER);
                        return;
                    end
                    ph  = PH_HDR;
                    pos = '0;
                end else begin
                    // A stream that stops inside the preamble is a header error.
                    if (fin) begin
                        raise_err(ERR_HEADER);
                        return;
                    end
                    pos = i + 1'b1;
                end
            end
            PH_HDR: begin
                if (i == 0) begin
                    csize = '0;
                    cid   = '0;
                end
                if (i < 4) begin
                    cid = {cid[IdW-9:0], b};
                    pos = i + 1'b1;
                end else if (i < 7) begin
                    csize[8*(i-4) +: 8] = b;
                    pos = i + 1'b1;
                end else begin
                    if (b != 0) begin
                        raise_err(ERR_BIG_BLOCK);
                        return;
                    end
                    if (cid == ID_FMT) kind = KIND_FMT;
                    else if (cid == ID_DATA) kind = KIND_DATA;
                    else kind = KIND_OTHER;
                    pos = '0;
                    // Empty chunks are skipped whatever their id.
                    if (csize != 0) begin
                        if (kind == KIND_DATA && !fmt_done) begin
                            raise_err(ERR_DATA_FIRST);
                            return;
                        end
                        ph = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                if (kind == KIND_FMT && i < FmtLen) fmt_mem[i[3:0]] = b;
                if (kind == KIND_DATA) emit(b, 1'b0, ERR_NONE, 1'b1);
                if (i + 1 >= csize) begin
                    ph  = PH_HDR;
                    pos = '0;
                    if (kind == KIND_FMT) begin
                        // Validate in a fixed order; the first failing test wins.
                        if (fmt_done) begin
                            raise_err(ERR_MULTI_FMT);
                        end else if (csize < FmtLen) begin
                            raise_err(ERR_FMT_SMALL);
                        end else if (fmt_mem[2] > MAX_CHANS || fmt_mem[3] != 0) begin
                            raise_err(ERR_CHANNELS);
                        end else if (fmt_mem[6] != 0 || fmt_mem[7] != 0) begin
                            raise_err(ERR_RATE);
                        end else if ((fmt_mem[14] != BITS_8 && fmt_mem[14] != BITS_16)
                                     || fmt_mem[15] != 0) begin
                            raise_err(ERR_BITS);
                        end else if ((fmt_mem[0] != CODEC_PCM && fmt_mem[0] != CODEC_ALAW
                                      && fmt_mem[0] != CODEC_ULAW) || fmt_mem[1] != 0) begin
                            raise_err(ERR_CODEC);
                        end else begin
                            if (fmt_mem[0] == CODEC_PCM) begin
                                codec_out = (fmt_mem[14] == BITS_8) ? PCM_8_CODE : PCM_16_CODE;
                            end else begin
                                codec_out = fmt_mem[0];
                            end
                            emit(HDR_TAG, 1'b0, ERR_NONE, 1'b0);
                            emit((fmt_mem[2] == MAX_CHANS) ? HDR_STEREO : HDR_MONO,
                                 1'b0, ERR_NONE, 1'b0);
                            emit(codec_out, 1'b0, ERR_NONE, 1'b0);
                            emit(fmt_mem[4], 1'b0, ERR_NONE, 1'b0);
                            emit(fmt_mem[5], 1'b0, ERR_NONE, 1'b1);
                            fmt_done = 1'b1;
                        end
                        if (halted) return;
                    end
                end else begin
                    pos = i + 1'b1;
                end
            end
            default: ;
        endcase
        // Once the end flag is taken, ignore everything until reset.
        if (fin) ph = PH_END;
    endtask

    // ------------------------------------------------------------------
    // Stream builders
    // ------------------------------------------------------------------
    task automatic put(input logic [ByteW-1:0] b, input logic fin = 1'b0);
        stream_q.push_back('{b, fin, hold_pending});
        hold_pending = 1'b0;
    endtask

    // Flag the newest request as the final byte of the stream.
    task automatic end_here();
        t_stream_req r;
        r = stream_q.pop_back();
        r.fin = 1'b1;
        stream_q.push_back(r);
    endtask

    // Emit the top byte first, which is how chunk ids arrive.
    task automatic put_word(input logic [IdW-1:0] w);
        for (int k = 3; k >= 0; k--) put(w[8*k +: 8]);
    endtask

    task automatic put_chunk_hdr(input logic [IdW-1:0] id, input logic [CountW-1:0] size,
                                 input logic [ByteW-1:0] top);
        put_word(id);
        put(size[7:0]);
        put(size[15:8]);
        put(size[23:16]);
        put(top);
    endtask

    task automatic put_bytes(input int n);
        repeat (n) put(ByteW'($urandom_range(255)));
    endtask

    // Build one fmt chunk with at most one fault; a cut chunk ends the stream early.
    task automatic put_fmt(input t_fmt_fault fault, input logic cut);
        logic [ByteW-1:0] f [20];
        int size;
        int sent;
        logic [ByteW-1:0] v;
        for (int k = 0; k < 20; k++) f[k] = ByteW'($urandom_range(255));
        case ($urandom_range(2))
            0:       f[0] = CODEC_PCM;
            1:       f[0] = CODEC_ALAW;
            default: f[0] = CODEC_ULAW;
        endcase
        f[1]  = 8'h00;
        f[2]  = ByteW'($urandom_range(2));
        f[3]  = 8'h00;
        f[6]  = 8'h00;
        f[7]  = 8'h00;
        f[14] = $urandom_range(1) ? BITS_16 : BITS_8;
        f[15] = 8'h00;
        size  = (fault == FMT_SMALL) ? $urandom_range(15, 1) : $urandom_range(20, 16);
        case (fault)
            FMT_CHAN: begin
                if ($urandom_range(1)) f[2] = ByteW'($urandom_range(255, 3));
                else f[3] = ByteW'($urandom_range(255, 1));
            end
            FMT_RATE: begin
                if ($urandom_range(1)) f[6] = ByteW'($urandom_range(255, 1));
                else f[7] = ByteW'($urandom_range(255, 1));
            end
            FMT_BITS: begin
                if ($urandom_range(1)) begin
                    v = ByteW'($urandom_range(255));
                    if (v == BITS_8 || v == BITS_16) v = v + 8'd1;
                    f[14] = v;
                end else begin
                    f[15] = ByteW'($urandom_range(255, 1));
                end
            end
            FMT_CODEC: begin
                if ($urandom_range(1)) begin
                    v = ByteW'($urandom_range(255));
                    if (v == CODEC_PCM || v == CODEC_ALAW || v == CODEC_ULAW) v = 8'h00;
                    f[0] = v;
                end else begin
                    f[1] = ByteW'($urandom_range(255, 1));
                end
            end
            default: ;
        endcase
        sent = cut ? $urandom_range(size - 1, 1) : size;
        put_chunk_hdr(ID_FMT, CountW'(size), 8'h00);
        for (int k = 0; k < sent; k++) put(f[k]);
        if (cut) end_here();
    endtask

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        t_opening    opening;
        t_closing    closing;
        t_stream_req r;
        int pick;
        int n;
        int idx;

        ph        = PH_RIFF;
        kind      = KIND_OTHER;
        pos       = '0;
        csize     = '0;
        cid       = '0;
        riff_good = 1'b1;
        fmt_done  = 1'b0;
        halted    = 1'b0;

        pick = $urandom_range(99);
        if (pick < 60) opening = OPEN_CLEAN;
        else opening = t_opening'($urandom_range(4, 1));

        // Preamble with extreme and random values in the ignored size field.
        put_word(TAG_RIFF);
        put(8'hFF);
        put(8'h00);
        put(ByteW'($urandom_range(255)));
        put(ByteW'($urandom_range(255)));
        put_word(TAG_WAVE);

        if (opening == OPEN_BAD_MAGIC) begin
            // Corrupt one of the checked preamble bytes.
            idx = $urandom_range(7);
            if (idx >= 4) idx = idx + 4;
            r = stream_q[idx];
            r.b = r.b ^ 8'($urandom_range(255, 1));
            stream_q[idx] = r;
        end else if (opening == OPEN_SHORT) begin
            n = $urandom_range(11, 1);
            while (stream_q.size() > n) stream_q.delete(stream_q.size() - 1);
            end_here();
        end else begin
            // Empty chunks of every kind are skipped; an id one bit away from
            // fmt must be treated as an unknown chunk.
            put_chunk_hdr(TAG_LIST, '0, 8'h00);
            put_chunk_hdr(ID_DATA, '0, 8'h00);
            put_chunk_hdr(ID_FMT, '0, 8'h00);
            put_chunk_hdr(ID_FMT ^ 32'h1, CountW'(3), 8'h00);
            put_bytes(3);

            if (opening == OPEN_DATA_FIRST) begin
                put_chunk_hdr(ID_DATA, CountW'($urandom_range(24, 1)), 8'h00);
            end else if (opening == OPEN_BAD_FMT) begin
                put_fmt(t_fmt_fault'($urandom_range(5, 1)), 1'b0);
            end else begin
                put_fmt(FMT_OK, 1'b0);
                // Drain the fmt header before any data goes in.
                hold_pending = 1'b1;
                put_chunk_hdr(ID_DATA, CountW'(4), 8'h00);
                put(8'h00);
                put(8'hFF);
                put(8'h80);
                put(8'h7F);

                while (stream_q.size() < BODY_ITEMS) begin
                    if ($urandom_range(99) < 5) hold_pending = 1'b1;
                    pick = $urandom_range(99);
                    if (pick < 60) begin
                        n = $urandom_range(24, 1);
                        put_chunk_hdr(ID_DATA, CountW'(n), 8'h00);
                        put_bytes(n);
                    end else if (pick < 85) begin
                        n = $urandom_range(12, 1);
                        put_chunk_hdr($urandom, CountW'(n), 8'h00);
                        put_bytes(n);
                    end else begin
                        case ($urandom_range(2))
                            0:       put_chunk_hdr(ID_DATA, '0, 8'h00);
                            1:       put_chunk_hdr(ID_FMT, '0, 8'h00);
                            default: put_chunk_hdr($urandom, '0, 8'h00);
                        endcase
                    end
                end

                closing = t_closing'($urandom_range(5));
                case (closing)
                    CLOSE_CLEAN: begin
                        n = $urandom_range(8, 1);
                        put_chunk_hdr(ID_DATA, CountW'(n), 8'h00);
                        put_bytes(n);
                        end_here();
                    end
                    CLOSE_CUT_BODY: begin
                        n = $urandom_range(16, 2);
                        put_chunk_hdr(ID_DATA, CountW'(n), 8'h00);
                        put_bytes($urandom_range(n - 1, 1));
                        end_here();
                    end
                    CLOSE_CUT_HDR: begin
                        put_chunk_hdr($urandom_range(1) ? ID_DATA : ID_FMT,
                                      CountW'($urandom_range(24, 1)), 8'h00);
                        repeat ($urandom_range(7, 1)) stream_q.delete(stream_q.size() - 1);
                        end_here();
                    end
                    CLOSE_BIG_BLOCK: begin
                        put_chunk_hdr($urandom_range(1) ? ID_DATA : $urandom,
                                      CountW'($urandom_range(8, 1)),
                                      ByteW'($urandom_range(255, 1)));
                    end
                    CLOSE_SECOND_FMT: put_fmt(FMT_OK, 1'b0);
                    default:          put_fmt(FMT_OK, 1'b1);
                endcase
            end
        end

        // Trailing bytes after the stream has stopped must be swallowed silently;
        // pad short streams so every run offers a full-length input sequence.
        repeat (10) put(ByteW'($urandom_range(255)), 1'($urandom_range(1)));
        while (stream_q.size() < STREAM_ITEMS) begin
            put(ByteW'($urandom_range(255)), 1'($urandom_range(1)));
        end

        while (stream_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (parsed_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Sender: sample the handshake, update the model on accept, then offer
    // the next request unless idling or draining.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                parse_wav_byte(i_in_byte, i_in_end);
            end
            if (!i_in_valid || o_in_ready) begin
                if (stream_q.size() != 0 && !(stream_q[0].hold && parsed_q.size() != 0)
                    && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                    next_req = stream_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_in_byte  <= next_req.b;
                    i_in_end   <= next_req.fin;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each accepted result against the oldest model result
    // and stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (parsed_q.size() == 0) begin
                    $display("%0t: unexpected result byte=%02h err=%0b code=%0d last=%0b",
                             $time, o_out_byte, o_out_error, o_error_code, o_out_last);
                    fail_cnt++;
                end else begin
                    head_res = parsed_q.pop_front();
                    if (o_out_byte !== head_res.b || o_out_error !== head_res.err
                        || o_error_code !== head_res.code || o_out_last !== head_res.last) begin
                        $display("%0t: mismatch expected byte=%02h err=%0b code=%0d last=%0b",
                                 $time, head_res.b, head_res.err, head_res.code,
                                 head_res.last);
                        $display("%0t:          actual   byte=%02h err=%0b code=%0d last=%0b",
                                 $time, o_out_byte, o_out_error, o_error_code, o_out_last);
                        fail_cnt++;
                    end
                end
            end
            i_out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

endmodule

/* wav_chunk_parser.f */
design/wcp_pkg.sv
design/wcp_front.sv
design/wcp_queue.sv
design/wcp_back.sv
design/wav_chunk_parser.sv
bench/tb.sv
